// File: rtl/hbas_pkg.sv
package hbas_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned SQ_W       = 62;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned INTERVAL_W = 63;
  localparam int unsigned BSUM_W     = 32;
  localparam int unsigned BF_W       = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned OP_W       = 2;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_FACTOR = 3'd0;

  localparam logic [BF_W-1:0]       BF_RESET     = 16'd2;
  localparam logic [BF_W-1:0]       BF_MIN       = 16'd2;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};

  // quotient magnitude never exceeds 2^15, so 17 quotient bits suffice
  localparam int unsigned    DIV_STEPS = 17;
  localparam logic [4:0]     DIV_CNT_INIT = 5'd17;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [IDX_W-1:0]           stage_index;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] stage_sum;
    logic [SQ_W-1:0]         stage_sum_squares;
    logic [COUNT_W-1:0]      stage_count;
    logic [INTERVAL_W-1:0]   stage_interval;
    logic                    stage_exists;
  } out_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
  } carry_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sum_squares;
    logic [COUNT_W-1:0]      count;
    logic                    active;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADD  = 3'b010,
    ST_READ = 3'b100
  } state_t;

endpackage

// File: rtl/hbas_div.sv
module hbas_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [hbas_pkg::BSUM_W-1:0]  dividend,
  input  logic [hbas_pkg::BF_W-1:0]           divisor,
  output logic                                busy,
  output hbas_pkg::carry_t                    result
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [4:0]                     cnt_r, cnt_nxt;
  logic                           neg_r, neg_nxt;
  logic [hbas_pkg::BF_W-1:0]      rem_r, rem_nxt;
  logic [hbas_pkg::DIV_STEPS-1:0] work_r, work_nxt;
  logic signed [hbas_pkg::SAMPLE_W-1:0] quot_r, quot_nxt;

  logic [hbas_pkg::BSUM_W-1:0]    mag;
  logic [hbas_pkg::BF_W:0]        trial;
  logic [hbas_pkg::BF_W:0]        diff;
  logic                           ge;
  logic [hbas_pkg::BF_W-1:0]      rem_step;
  logic [hbas_pkg::DIV_STEPS-1:0] work_step;
  logic [hbas_pkg::DIV_STEPS-1:0] q_signed;

  always_comb begin
    mag       = dividend[hbas_pkg::BSUM_W-1] ? (32'd0 - dividend) : dividend;
    trial     = {rem_r, work_r[hbas_pkg::DIV_STEPS-1]};
    diff      = trial - {1'b0, divisor};
    ge        = trial >= {1'b0, divisor};
    rem_step  = ge ? diff[hbas_pkg::BF_W-1:0] : trial[hbas_pkg::BF_W-1:0];
    work_step = {work_r[hbas_pkg::DIV_STEPS-2:0], ge};
    q_signed  = neg_r ? (17'd0 - work_step) : work_step;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = hbas_pkg::DIV_CNT_INIT;
      neg_nxt  = dividend[hbas_pkg::BSUM_W-1];
      rem_nxt  = {2'b00, mag[30:17]};
      work_nxt = mag[16:0];
    end else if (busy_r) begin
      rem_nxt  = rem_step;
      work_nxt = work_step;
      cnt_nxt  = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quot_nxt = q_signed[hbas_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    quot_r <= quot_nxt;
  end

  assign busy         = busy_r;
  assign result.valid = done_r;
  assign result.value = quot_r;

endmodule

// File: rtl/hbas_cell.sv
module hbas_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic [hbas_pkg::BF_W-1:0]  block_factor,
  input  hbas_pkg::carry_t           carry_in,
  output hbas_pkg::carry_t           carry_out,
  output logic                       busy,
  output hbas_pkg::stat_t            stats
);

  logic signed [hbas_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [hbas_pkg::SQ_W-1:0]          sq_r, sq_nxt;
  logic [hbas_pkg::COUNT_W-1:0]       count_r, count_nxt;
  logic signed [hbas_pkg::BSUM_W-1:0] bsum_r, bsum_nxt;
  logic [hbas_pkg::BF_W-1:0]          bcnt_r, bcnt_nxt;
  logic                               active_r, active_nxt;

  logic                               take;
  logic                               blk_done;
  logic signed [31:0]                 square;
  logic signed [hbas_pkg::BSUM_W-1:0] bsum_add;
  logic [hbas_pkg::BF_W-1:0]          bcnt_add;

  always_comb begin
    take     = carry_in.valid && (count_r != hbas_pkg::COUNT_MAX);
    square   = carry_in.value * carry_in.value;
    bsum_add = bsum_r + {{16{carry_in.value[15]}}, carry_in.value};
    bcnt_add = bcnt_r + 16'd1;
    blk_done = take && (bcnt_add == block_factor);

    sum_nxt    = sum_r;
    sq_nxt     = sq_r;
    count_nxt  = count_r;
    bsum_nxt   = bsum_r;
    bcnt_nxt   = bcnt_r;
    active_nxt = active_r || carry_in.valid;
    if (take) begin
      sum_nxt   = sum_r + {{32{carry_in.value[15]}}, carry_in.value};
      sq_nxt    = sq_r + {30'd0, square};
      count_nxt = count_r + 32'd1;
      bsum_nxt  = blk_done ? '0 : bsum_add;
      bcnt_nxt  = blk_done ? '0 : bcnt_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      sum_r    <= '0;
      sq_r     <= '0;
      count_r  <= '0;
      bsum_r   <= '0;
      bcnt_r   <= '0;
      active_r <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      sq_r     <= sq_nxt;
      count_r  <= count_nxt;
      bsum_r   <= bsum_nxt;
      bcnt_r   <= bcnt_nxt;
      active_r <= active_nxt;
    end
  end

  // block average, truncated toward zero
  hbas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (blk_done),
    .dividend (bsum_add),
    .divisor  (block_factor),
    .busy     (busy),
    .result   (carry_out)
  );

  assign stats.sum         = sum_r;
  assign stats.sum_squares = sq_r;
  assign stats.count       = count_r;
  assign stats.active      = active_r;

endmodule

// File: rtl/hierarchical_block_average_stats.sv
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  hbas_pkg::in_t (operation, sample, stage)
// out_      output     out_valid/out_stall hbas_pkg::out_t (read results only)
// cfg       apb        psel/penable/pready block_factor at byte 0
//
// add: in_ stalls until every stage whose block fills has run the
//   17-step serial divider inside that stage's cell
// read: stage_index serial interval multiplies, then waits for a free output register
// clear and unused operation codes: handled in idle, in_ does not stall
// rst_n is synchronous; it clears every stage and sets block_factor to 2
// a pending result in the output register does not stall in_; only the end
//   of the next read waits for it
module hierarchical_block_average_stats #(
  parameter int unsigned NUM_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  hbas_pkg::in_t                      in_data,

  output logic                               out_valid,
  input  logic                               out_stall,
  output hbas_pkg::out_t                     out_data,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hbas_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hbas_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hbas_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  hbas_pkg::state_t                    state_r, state_nxt;
  logic [hbas_pkg::BF_W-1:0]           block_factor_r, block_factor_nxt;
  logic [hbas_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic [hbas_pkg::IDX_W-1:0]          cnt_r, cnt_nxt;
  logic [hbas_pkg::INTERVAL_W-1:0]     ival_r, ival_nxt;
  logic                                out_valid_r, out_valid_nxt;
  hbas_pkg::out_t                      out_data_r, out_data_nxt;

  hbas_pkg::carry_t                    carry [NUM_STAGES+1];
  hbas_pkg::stat_t                     stats [NUM_STAGES];
  logic [NUM_STAGES-1:0]               busy_vec;
  logic [NUM_STAGES-1:0]               carry_vec;

  logic                                accept;
  logic                                cfg_write;
  logic                                clear;
  logic [78:0]                         prod;
  hbas_pkg::out_t                      rd_data;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != hbas_pkg::ST_IDLE);
  assign clear     = accept && (in_data.operation == hbas_pkg::OP_CLEAR);
  assign cfg_write = psel && penable && pwrite && pready;

  assign carry[0].valid = accept && (in_data.operation == hbas_pkg::OP_ADD);
  assign carry[0].value = in_data.sample_value;

  genvar g;
  generate
    for (g = 0; g < NUM_STAGES; g++) begin : g_cell
      hbas_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (clear),
        .block_factor (block_factor_r),
        .carry_in     (carry[g]),
        .carry_out    (carry[g+1]),
        .busy         (busy_vec[g]),
        .stats        (stats[g])
      );
      assign carry_vec[g] = carry[g+1].valid;
    end
  endgenerate

  always_comb begin
    rd_data = '0;
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (int'(idx_r) == s) begin
        rd_data.stage_sum         = stats[s].sum;
        rd_data.stage_sum_squares = stats[s].sum_squares;
        rd_data.stage_count       = stats[s].count;
        rd_data.stage_exists      = (s == 0) || stats[s].active;
      end
    end
    rd_data.stage_interval = ival_r;
  end

  always_comb begin
    prod = 79'(ival_r) * 79'(block_factor_r);

    state_nxt        = state_r;
    block_factor_nxt = block_factor_r;
    idx_nxt          = idx_r;
    cnt_nxt          = cnt_r;
    ival_nxt         = ival_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    if (cfg_write && (paddr == hbas_pkg::REG_BLOCK_FACTOR) &&
        (pwdata[hbas_pkg::BF_W-1:0] >= hbas_pkg::BF_MIN) && (stats[0].count == '0)) begin
      block_factor_nxt = pwdata[hbas_pkg::BF_W-1:0];
    end

    case (state_r)
      hbas_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            hbas_pkg::OP_ADD: begin
              state_nxt = hbas_pkg::ST_ADD;
            end
            hbas_pkg::OP_READ: begin
              state_nxt = hbas_pkg::ST_READ;
              idx_nxt   = in_data.stage_index;
              cnt_nxt   = in_data.stage_index;
              ival_nxt  = 63'd1;
            end
            default: begin
              state_nxt = hbas_pkg::ST_IDLE;
            end
          endcase
        end
      end
      hbas_pkg::ST_ADD: begin
        if (!(|busy_vec) && !(|carry_vec)) begin
          state_nxt = hbas_pkg::ST_IDLE;
        end
      end
      hbas_pkg::ST_READ: begin
        if (cnt_r != '0) begin
          cnt_nxt  = cnt_r - 4'd1;
          ival_nxt = (prod[78:63] != '0) ? hbas_pkg::INTERVAL_MAX : prod[62:0];
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data;
          state_nxt     = hbas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hbas_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= hbas_pkg::ST_IDLE;
      block_factor_r <= hbas_pkg::BF_RESET;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
    end else begin
      state_r        <= state_nxt;
      block_factor_r <= block_factor_nxt;
      out_valid_r    <= out_valid_nxt;
      cnt_r          <= cnt_nxt;
    end
    idx_r      <= idx_nxt;
    ival_r     <= ival_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr == hbas_pkg::REG_BLOCK_FACTOR) ? {16'd0, block_factor_r} : '0;

  // only one cell divides at a time in the cascade
  a_one_divider: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(busy_vec))
    else $error("more than one stage dividing");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hbas_pkg::ST_IDLE) |-> (!(|busy_vec) && !(|carry_vec)))
    else $error("cascade still running while idle");

  a_bf_legal: assert property (@(posedge clk) disable iff (!rst_n)
    block_factor_r >= hbas_pkg::BF_MIN)
    else $error("block factor below minimum");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == hbas_pkg::ST_READ))
    else $error("result without read transaction");

endmodule
